// ===== src/upv_pkg.sv =====
// ----------------------------------------------------------------------------
// upv_pkg: shared types and constants for the URL path validator
// Character codes, the per-path state record and its cleared value.
// ----------------------------------------------------------------------------
package upv_pkg;

  // Character codes
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_QUERY  = 8'h3f;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW    = 8'h21;
  localparam logic [7:0] CH_HIGH   = 8'h7e;

  localparam logic [1:0] SEG_LEN_MAX = 2'd3;

  // State carried from one byte of a path to the next
  typedef struct packed {
    logic       at_first_byte;
    logic       failed_flag;
    logic       query_seen;
    logic [1:0] segment_length;
    logic       segment_all_dots;
    logic       path_length_one;
  } upv_state_t;

  localparam upv_state_t PATH_CLEAR = '{
    at_first_byte:    1'b1,
    failed_flag:      1'b0,
    query_seen:       1'b0,
    segment_length:   2'd0,
    segment_all_dots: 1'b1,
    path_length_one:  1'b1
  };

  // Current segment is exactly "." or ".."
  function automatic logic dot_segment(input upv_state_t st);
    dot_segment = st.segment_all_dots &&
                  (st.segment_length == 2'd1 || st.segment_length == 2'd2);
  endfunction

endpackage

// ===== src/upv_rule_logic.sv =====
// ----------------------------------------------------------------------------
// upv_rule_logic: per-byte rule evaluation
// Applies the path rules to one byte and gives the next state and verdict.
// ----------------------------------------------------------------------------
module upv_rule_logic (
  input  upv_pkg::upv_state_t state_cur,
  input  logic [7:0]          path_byte,
  input  logic                last_byte,
  output upv_pkg::upv_state_t state_next,
  output logic                path_ok
);
  import upv_pkg::*;

  upv_state_t upd;
  logic       bad_char;
  logic       is_sep;

  assign bad_char = (path_byte < CH_LOW) || (path_byte > CH_HIGH) ||
                    (path_byte == CH_HASH) || (path_byte == CH_BSLASH);
  assign is_sep   = (path_byte == CH_SLASH) || (path_byte == CH_QUERY);

  // State update for this byte
  always_comb begin
    upd = state_cur;
    if (state_cur.at_first_byte) begin
      if (path_byte != CH_SLASH) upd.failed_flag = 1'b1;
      upd.at_first_byte    = 1'b0;
      upd.segment_length   = 2'd0;
      upd.segment_all_dots = 1'b1;
    end else begin
      upd.path_length_one = 1'b0;
      if (bad_char) begin
        upd.failed_flag = 1'b1;
      end else if (!state_cur.query_seen && is_sep) begin
        if (dot_segment(state_cur)) upd.failed_flag = 1'b1;
        if (path_byte == CH_QUERY) begin
          upd.query_seen = 1'b1;
        end else begin
          upd.segment_length   = 2'd0;
          upd.segment_all_dots = 1'b1;
        end
      end else if (state_cur.query_seen && path_byte == CH_QUERY) begin
        // second '?'
        upd.failed_flag = 1'b1;
      end else if (!state_cur.query_seen) begin
        if (state_cur.segment_length != SEG_LEN_MAX) begin
          upd.segment_length = state_cur.segment_length + 2'd1;
        end
        if (path_byte != CH_DOT) upd.segment_all_dots = 1'b0;
      end
    end
  end

  // Verdict and clear on the last byte
  always_comb begin
    path_ok = !upd.failed_flag && !upd.path_length_one &&
              !(!upd.query_seen && dot_segment(upd));
    state_next = last_byte ? PATH_CLEAR : upd;
  end

endmodule

// ===== src/upv_out_reg.sv =====
// ----------------------------------------------------------------------------
// upv_out_reg: result register
// Holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module upv_out_reg (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic ok_in,
  input  logic out_ready,
  output logic out_valid,
  output logic path_ok,
  output logic free
);

  // Can take a new verdict when empty or being drained this cycle
  assign free = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) path_ok <= ok_in;
  end

endmodule

// ===== src/url_path_validator_top.sv =====
// ----------------------------------------------------------------------------
// url_path_validator_top: streaming HTTP request path checker
// Takes a path one byte per item and gives one verdict on its last byte.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------
//   input   | in_valid, in_ready  | path_byte, last_byte
//   output  | out_valid, out_ready| path_ok
//
// One byte is accepted per cycle while the input is not stalled. Each
// byte is held in the input register, where the rules are applied; a
// last byte writes its verdict to the result register, which raises
// out_valid until out_ready takes the verdict. Only a full result
// register that is not drained stalls a last byte, and with it the
// input. Reset clears the path state and both valid flags.
// ----------------------------------------------------------------------------
module url_path_validator_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] path_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       path_ok
);
  import upv_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_adv;
  logic       out_free;
  logic       verdict;
  upv_state_t st;
  upv_state_t st_next;

  // Input stage moves on unless a verdict is blocked
  assign s1_adv   = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= path_byte;
      s1_last <= last_byte;
    end
  end

  // Rule evaluation
  upv_rule_logic u_rules (
    .state_cur  (st),
    .path_byte  (s1_byte),
    .last_byte  (s1_last),
    .state_next (st_next),
    .path_ok    (verdict)
  );

  // Path state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PATH_CLEAR;
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  // Result register
  upv_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_adv && s1_last),
    .ok_in     (verdict),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .path_ok   (path_ok),
    .free      (out_free)
  );

  // State is cleared after a last byte is processed
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (st.at_first_byte && !st.failed_flag && !st.query_seen))
    else $error("path state not cleared after last byte");

  // The first-byte state implies that the single-byte marker is set
  a_len_one_first: assert property (@(posedge clk) disable iff (rst)
    st.at_first_byte |-> st.path_length_one)
    else $error("first-byte state without single-length marker");

  // A stalled byte stays in the input stage
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_byte) && $stable(s1_last)))
    else $error("input stage lost a stalled item");

  // Non-last bytes never create a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(s1_adv && s1_last)) |=> !out_valid)
    else $error("result appeared without a last byte");

endmodule
